/* rtl/core/mss_pkg.sv */
// Shared types, constants and helpers for the MIDI step sequencer.
// No dependencies; imported by the controller, the datapath and the top level.
package mss_pkg;

  localparam int unsigned STEPS = 8;
  localparam int unsigned IDX_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned SC_W  = $clog2(2 * STEPS + 1);

  localparam logic [7:0] STATUS_NOTE_ON = 8'h90;
  localparam logic [6:0] NOTE_RESET     = 7'd60;
  localparam logic [6:0] VEL_RESET      = 7'd64;
  localparam logic [2:0] KEY_COUNT      = 3'd6;

  typedef enum logic [1:0] {
    MODE_PRESS   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_TICK    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STATUS,
    ST_NOTE,
    ST_VEL
  } state_t;

  typedef enum logic [1:0] {
    BYTE_STATUS,
    BYTE_NOTE,
    BYTE_VEL
  } byte_sel_t;

  typedef struct packed {
    logic      load;
    logic      emit;
    byte_sel_t sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_ok;
    logic status_sent;
  } dp_status_t;

  function automatic logic [6:0] key_note(input logic [2:0] button);
    logic [6:0] note;
    case (button)
      3'd0:    note = 7'h3C;
      3'd1:    note = 7'd60;
      3'd2:    note = 7'd62;
      3'd3:    note = 7'd64;
      3'd4:    note = 7'd67;
      3'd5:    note = 7'd69;
      default: note = 7'd60;
    endcase
    return note;
  endfunction

endpackage

/* rtl/core/midi_step_sequencer_top.sv */
// MIDI step sequencer top level: one transaction in, two or three bytes out.
// First byte in the cycle after start is taken; then one byte per cycle.
// Three bytes with the status byte, two without; the next start is taken
// during the final byte's cycle. Invalid buttons and mode 3 give no bytes.
// Reset is synchronous: steps read as note 60 / velocity 64, pointers and
// status clear.
module midi_step_sequencer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_mode,
  input  logic [2:0] in_button,
  input  logic [6:0] in_play_velocity,
  input  logic [6:0] in_record_velocity,
  output logic       out_valid,
  output logic [7:0] out_midi_byte,
  output logic       out_last_byte
);
  import mss_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mss_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  mss_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_mode            (in_mode),
    .in_button          (in_button),
    .in_play_velocity   (in_play_velocity),
    .in_record_velocity (in_record_velocity),
    .out_midi_byte      (out_midi_byte),
    .out_last_byte      (out_last_byte)
  );

  assign out_valid = cmd.emit;

`ifndef SYNTHESIS
  a_mid_msg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_byte |-> busy)
    else $error("start could be taken in the middle of a message");

  a_tick_emits: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode == MODE_TICK |=> out_valid && !out_last_byte)
    else $error("tick transaction did not start a message");

  a_status_then_note: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_midi_byte == STATUS_NOTE_ON && !out_last_byte
    |=> out_valid && !out_last_byte && !out_midi_byte[7])
    else $error("status byte not followed by a note byte");

  // the running status flag is set at the edge that loads a valid transaction
  a_status_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_midi_byte[7] |-> !$past(status.status_sent))
    else $error("status byte repeated under running status");
`endif

endmodule

/* rtl/core/mss_ctrl.sv */
// Sequencer controller: accepts a transaction and walks the bytes of one message.
// Depends on mss_pkg.
module mss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mss_pkg::dp_status_t status,
  output mss_pkg::ctrl_cmd_t  cmd
);
  import mss_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    // take the next transaction while the final byte goes out
    busy      = !(state_r == ST_IDLE || state_r == ST_VEL);
    accept    = start && !busy;
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.emit  = (state_r != ST_IDLE);
    cmd.sel   = BYTE_STATUS;
    case (state_r)
      ST_IDLE: begin
        state_nxt = ST_IDLE;
      end
      ST_STATUS: begin
        cmd.sel   = BYTE_STATUS;
        state_nxt = ST_NOTE;
      end
      ST_NOTE: begin
        cmd.sel   = BYTE_NOTE;
        state_nxt = ST_VEL;
      end
      ST_VEL: begin
        cmd.sel   = BYTE_VEL;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (accept) begin
      cmd.load = 1'b1;
      if (!status.item_ok) begin
        state_nxt = ST_IDLE;
      end else if (status.status_sent) begin
        state_nxt = ST_NOTE;
      end else begin
        state_nxt = ST_STATUS;
      end
    end
  end

endmodule

/* rtl/core/mss_datapath.sv */
// Sequencer datapath: step memories, write pointer, step counter, running status
// and the output byte select. Depends on mss_pkg.
module mss_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mss_pkg::ctrl_cmd_t   cmd,
  output mss_pkg::dp_status_t  status,
  input  logic [1:0]           in_mode,
  input  logic [2:0]           in_button,
  input  logic [6:0]           in_play_velocity,
  input  logic [6:0]           in_record_velocity,
  output logic [7:0]           out_midi_byte,
  output logic                 out_last_byte
);
  import mss_pkg::*;

  logic [6:0] note_mem [STEPS];
  logic [6:0] vel_mem  [STEPS];
  logic       valid_r  [STEPS];

  logic [IDX_W-1:0] wp_r, wp_nxt;
  logic [SC_W-1:0]  sc_r, sc_nxt;
  logic             sent_r;

  logic [6:0]       rd_note_r, rd_vel_r;
  logic             rd_valid_r;
  logic             tick_r, mem_vel_r;
  logic [6:0]       live_note_r, live_vel_r;

  logic             is_press, is_release, is_tick, key_ok;
  logic             wr_en;
  logic [SC_W-1:0]  half, half_m1;
  logic [IDX_W-1:0] tick_idx;
  logic [6:0]       note_byte, vel_byte;

  always_comb begin
    is_press       = (in_mode == MODE_PRESS);
    is_release     = (in_mode == MODE_RELEASE);
    is_tick        = (in_mode == MODE_TICK);
    key_ok         = (in_button < KEY_COUNT);
    status.item_ok = ((is_press || is_release) && key_ok) || is_tick;
    status.status_sent = sent_r;
    wr_en          = cmd.load && is_press && key_ok;

    half    = sc_r >> 1;
    half_m1 = half - 1'b1;
    if (sc_r[0]) begin
      tick_idx = half[IDX_W-1:0];
    end else if (sc_r == '0) begin
      tick_idx = '0;
    end else begin
      tick_idx = half_m1[IDX_W-1:0];
    end

    wp_nxt = (wp_r == IDX_W'(STEPS - 1)) ? '0 : wp_r + 1'b1;
    // wrap from the top count back to one
    sc_nxt = (sc_r == SC_W'(2 * STEPS)) ? SC_W'(1) : sc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      sc_r   <= '0;
      sent_r <= 1'b0;
    end else if (cmd.load) begin
      if (wr_en) begin
        wp_r <= wp_nxt;
      end
      if (is_tick) begin
        sc_r <= sc_nxt;
      end
      if (status.item_ok) begin
        sent_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STEPS; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (wr_en) begin
      valid_r[wp_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      note_mem[wp_r] <= key_note(in_button);
      vel_mem[wp_r]  <= in_record_velocity;
    end
    if (cmd.load) begin
      rd_note_r   <= note_mem[tick_idx];
      rd_vel_r    <= vel_mem[tick_idx];
      rd_valid_r  <= valid_r[tick_idx];
      tick_r      <= is_tick;
      mem_vel_r   <= is_tick && sc_r[0];
      live_note_r <= key_note(in_button);
      live_vel_r  <= is_press ? in_play_velocity : 7'd0;
    end
  end

  always_comb begin
    if (tick_r) begin
      note_byte = rd_valid_r ? rd_note_r : NOTE_RESET;
    end else begin
      note_byte = live_note_r;
    end
    if (mem_vel_r) begin
      vel_byte = rd_valid_r ? rd_vel_r : VEL_RESET;
    end else begin
      vel_byte = live_vel_r;
    end
    out_last_byte = 1'b0;
    case (cmd.sel)
      BYTE_STATUS: out_midi_byte = STATUS_NOTE_ON;
      BYTE_NOTE:   out_midi_byte = {1'b0, note_byte};
      BYTE_VEL: begin
        out_midi_byte = {1'b0, vel_byte};
        out_last_byte = 1'b1;
      end
      default:     out_midi_byte = STATUS_NOTE_ON;
    endcase
  end

endmodule
